@@ hdl/spc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg: shared constants and types of the slotted page compactor
// Sizes of the slot directory store, field widths, result codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int MaxSlots  = 32;
  localparam int PageBytes = 4096;

  localparam int OffW  = 13;
  localparam int SizeW = 13;
  localparam int SlotW = 6;
  localparam int KindW = 2;

  localparam int IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int CntW = $clog2(MaxSlots + 1);
  localparam int CurW = $clog2(PageBytes + 1);
  localparam int CmpW = (CurW > SizeW) ? CurW : SizeW;

  localparam int InDataW  = 32;
  localparam int OutDataW = 48;

  typedef enum logic [KindW-1:0] {
    KIND_MOVE = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_DONE = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DEL_WAIT,
    ST_DEL_CHK,
    ST_MV_START,
    ST_MV_FILL,
    ST_MV_SCAN,
    ST_MV_EMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             deleted;
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  offset;
  } entry_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic best_clr;
    logic exam;
    logic emit_del;
    logic emit_move;
    logic emit_done;
    logic run_clr;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic rd_idx_last;
    logic rd_deleted;
    logic best_found;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/spc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_ctrl: compaction sequencer
// Walks load, deleted-slot sweep, repeated max-offset scans and the final
// done request, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module spc_ctrl
  import spc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_axis_tvalid,
  input  wire logic    s_axis_tlast,
  output logic         s_axis_tready,
  input  wire status_t sts_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          if (s_axis_tlast) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_DEL_WAIT;
          end
        end
      end
      // let the read data catch up with the index
      ST_DEL_WAIT: begin
        state_d = ST_DEL_CHK;
      end
      ST_DEL_CHK: begin
        if (!sts_i.rd_deleted || sts_i.out_free) begin
          cmd_o.emit_del = sts_i.rd_deleted;
          if (sts_i.idx_last) begin
            state_d = ST_MV_START;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_DEL_WAIT;
          end
        end
      end
      ST_MV_START: begin
        cmd_o.idx_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
        state_d        = ST_MV_FILL;
      end
      ST_MV_FILL: begin
        cmd_o.idx_inc = !sts_i.idx_last;
        state_d       = ST_MV_SCAN;
      end
      // one slot examined per cycle, reads run one ahead
      ST_MV_SCAN: begin
        cmd_o.exam    = 1'b1;
        cmd_o.idx_inc = !sts_i.idx_last;
        if (sts_i.rd_idx_last) begin
          state_d = ST_MV_EMIT;
        end
      end
      ST_MV_EMIT: begin
        if (!sts_i.best_found) begin
          state_d = ST_DONE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_move = 1'b1;
          state_d         = ST_MV_START;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          cmd_o.run_clr   = 1'b1;
          state_d         = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/spc_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spc_dpath: slot directory store, scan datapath and result register
// Holds the loaded entries in a memory, tracks emitted slots, keeps the best
// candidate of a scan, the free-end cursor and the outgoing result.
// ----------------------------------------------------------------------------
module spc_dpath
  import spc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  sts_o,
  input  wire entry_t              entry_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output result_kind_e             out_kind_o,
  output logic [SlotW-1:0]         out_slot_o,
  output logic [OffW-1:0]          out_old_o,
  output logic [OffW-1:0]          out_new_o,
  output logic [SizeW-1:0]         out_size_o,
  output logic                     out_ovf_o,
  output logic                     out_last_o
);

  entry_t            mem_q [MaxSlots];
  entry_t            rd_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   cnt_q;
  logic [MaxSlots-1:0] marks_q;
  logic              best_found_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [OffW-1:0]   best_off_q;
  logic [SizeW-1:0]  best_size_q;
  logic [CurW-1:0]   cursor_q, cursor_d;
  logic              ovf_q, ovf_d;
  logic              out_vld_q;
  logic              cnt_full;
  logic              cand;
  logic              emit_any;

  assign cnt_full = (cnt_q == CntW'(MaxSlots));
  assign emit_any = cmd_i.emit_del | cmd_i.emit_move | cmd_i.emit_done;
  assign cand     = !marks_q[rd_idx_q] && (!best_found_q || (rd_q.offset > best_off_q));

  assign sts_o.idx_last    = (CntW'(idx_q) == cnt_q - CntW'(1));
  assign sts_o.rd_idx_last = (CntW'(rd_idx_q) == cnt_q - CntW'(1));
  assign sts_o.rd_deleted  = rd_q.deleted;
  assign sts_o.best_found  = best_found_q;
  assign sts_o.out_free    = !out_vld_q || out_ready_i;

  // saturate at zero once the live records no longer fit
  always_comb begin
    if (CmpW'(best_size_q) > CmpW'(cursor_q)) begin
      cursor_d = '0;
      ovf_d    = 1'b1;
    end else begin
      cursor_d = cursor_q - CurW'(best_size_q);
      ovf_d    = ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !cnt_full) begin
      mem_q[cnt_q[IdxW-1:0]] <= entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= mem_q[idx_q];
    rd_idx_q <= idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      idx_q        <= '0;
      marks_q      <= '0;
      best_found_q <= 1'b0;
      cursor_q     <= CurW'(PageBytes);
      ovf_q        <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.run_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.load && !cnt_full) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.best_clr) begin
        best_found_q <= 1'b0;
      end else if (cmd_i.exam && cand) begin
        best_found_q <= 1'b1;
      end
      if (cmd_i.run_clr) begin
        marks_q  <= '0;
        cursor_q <= CurW'(PageBytes);
        ovf_q    <= 1'b0;
      end else begin
        if (cmd_i.emit_del) begin
          marks_q[rd_idx_q] <= 1'b1;
        end
        if (cmd_i.emit_move) begin
          marks_q[best_idx_q] <= 1'b1;
          cursor_q            <= cursor_d;
          ovf_q               <= ovf_d;
        end
      end
      if (emit_any) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // best candidate of the running scan, and the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exam && cand) begin
      best_idx_q  <= rd_idx_q;
      best_off_q  <= rd_q.offset;
      best_size_q <= rd_q.size;
    end
    if (cmd_i.emit_del) begin
      out_kind_o <= KIND_DEL;
      out_slot_o <= SlotW'(rd_idx_q);
      out_old_o  <= rd_q.offset;
      out_new_o  <= rd_q.offset;
      out_size_o <= '0;
      out_ovf_o  <= 1'b0;
      out_last_o <= 1'b0;
    end else if (cmd_i.emit_move) begin
      out_kind_o <= KIND_MOVE;
      out_slot_o <= SlotW'(best_idx_q);
      out_old_o  <= best_off_q;
      out_new_o  <= OffW'(cursor_d);
      out_size_o <= best_size_q;
      out_ovf_o  <= ovf_d;
      out_last_o <= 1'b0;
    end else if (cmd_i.emit_done) begin
      out_kind_o <= KIND_DONE;
      out_slot_o <= '0;
      out_old_o  <= '0;
      out_new_o  <= OffW'(cursor_q);
      out_size_o <= '0;
      out_ovf_o  <= ovf_q;
      out_last_o <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
`default_nettype wire

@@ hdl/slotted_page_compactor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Loading accepts one directory entry per cycle; the entry with tlast starts compaction.
// Deleted-slot sweep: each stored slot waits for its memory read (registered on the scan index), then is checked.
// Each scan of the stored slots runs on the single registered read port; there is one
// scan per move request plus a final scan that finds nothing, then the done request.
// Every request waits while the output register holds an earlier one that is not yet taken.
// Reset (async, active low) clears control state only; the directory needs no clearing pass.
// ----------------------------------------------------------------------------
// slotted_page_compactor: top level
// Takes a page's slot directory and issues size-cleared, move and done
// requests that pack live records against the page end.
// ----------------------------------------------------------------------------
module slotted_page_compactor
  import spc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // entry_offset[12:0], entry_size[25:13]
  input  wire logic                s_axis_tuser,   // entry_deleted
  input  wire logic                s_axis_tlast,   // entry_last
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // slot_number[5:0], old_offset[18:6],
                                                   // new_offset[31:19], record_size[44:32],
                                                   // overflow[45]
  output logic [KindW-1:0]         m_axis_tuser,   // result_kind
  output logic                     m_axis_tlast    // final_res
);

  cmd_t         cmd;
  status_t      sts;
  entry_t       entry;
  result_kind_e out_kind;
  logic [SlotW-1:0] out_slot;
  logic [OffW-1:0]  out_old;
  logic [OffW-1:0]  out_new;
  logic [SizeW-1:0] out_size;
  logic             out_ovf;

  assign entry.offset  = s_axis_tdata[OffW-1:0];
  assign entry.size    = s_axis_tdata[OffW+SizeW-1:OffW];
  assign entry.deleted = s_axis_tuser;

  spc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  spc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .entry_i     (entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_slot_o  (out_slot),
    .out_old_o   (out_old),
    .out_new_o   (out_new),
    .out_size_o  (out_size),
    .out_ovf_o   (out_ovf),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {2'b00, out_ovf, out_size, out_new, out_old, out_slot};

  // the done request is always the end of a run and carries no slot
  a_done_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tuser == KIND_DONE) && (out_slot == '0))
    else $error("done request with wrong kind or slot");

  // a deleted slot never moves bytes and never reports overflow
  a_del_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DEL) |-> (out_size == '0) && !out_ovf
      && (out_old == out_new))
    else $error("deleted slot request carries size or overflow");

  // hold a stalled request unchanged until it is taken
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("request changed while stalled");

endmodule
`default_nettype wire

@@ bench/tb_slotted_page_compactor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slotted_page_compactor: self-checking bench for the slotted page compactor
// Streams slot directories into the block. A local planner works out each
// compaction, and every size-cleared, move and done request is checked in
// order. Stimulus covers directed pages, full directories and random pages,
// with idle and stall phases on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_slotted_page_compactor;
  import spc_pkg::*;

  localparam int DrainCycles   = 100;
  localparam int HoldOffCycles = 3000;
  localparam int MaxReports    = 10;

  typedef struct packed {
    result_kind_e     kind;
    logic [SlotW-1:0] slot;
    logic [OffW-1:0]  old_off;
    logic [OffW-1:0]  new_off;
    logic [SizeW-1:0] size;
    logic             ovf;
    logic             fin;
  } request_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // entry_offset[12:0], entry_size[25:13]
  logic                s_axis_tuser  = 1'b0;  // entry_deleted
  logic                s_axis_tlast  = 1'b0;  // entry_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // slot_number[5:0], old_offset[18:6],
                                      // new_offset[31:19], record_size[44:32],
                                      // overflow[45]
  logic [KindW-1:0]    m_axis_tuser;  // result_kind
  logic                m_axis_tlast;  // final_res

  // planner state: the directory of the page being loaded
  logic [OffW-1:0]  dir_offset  [MaxSlots];
  logic [SizeW-1:0] dir_size    [MaxSlots];
  logic             dir_deleted [MaxSlots];
  int               dir_count = 0;
  request_t         awaited_requests [$];

  int unsigned send_idle_pct    = 0;
  int unsigned recv_stall_pct   = 0;
  int          hold_off_request = 0;

  int fail_count       = 0;
  int requests_checked = 0;
  int pages_done       = 0;
  int overflow_pages   = 0;
  int entries_stored   = 0;
  int entries_ignored  = 0;

  slotted_page_compactor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic string fmt_request(request_t r);
    return $sformatf("kind=%0d slot=%0d old=%0d new=%0d size=%0d ovf=%0d fin=%0d",
                     r.kind, r.slot, r.old_off, r.new_off, r.size, r.ovf, r.fin);
  endfunction

  // Store one directory entry; on the last one, plan the whole compaction.
  function automatic void plan_entry(logic [OffW-1:0] off, logic [SizeW-1:0] sz,
                                     logic del, logic last);
    logic [OffW-1:0] pack_cursor;
    logic            ovf;
    logic            placed [MaxSlots];
    int              best;
    if (dir_count < MaxSlots) begin
      dir_offset[dir_count]  = off;
      dir_size[dir_count]    = sz;
      dir_deleted[dir_count] = del;
      dir_count++;
      entries_stored++;
    end else begin
      entries_ignored++;
    end
    if (!last) return;

    pack_cursor = OffW'(PageBytes);
    ovf         = 1'b0;
    for (int i = 0; i < dir_count; i++) begin
      placed[i] = dir_deleted[i];
      if (dir_deleted[i])
        awaited_requests.push_back('{KIND_DEL, SlotW'(i), dir_offset[i], dir_offset[i],
                                     '0, 1'b0, 1'b0});
    end
    // pick highest old offset first; strict compare keeps the lower slot on ties
    forever begin
      best = -1;
      for (int i = 0; i < dir_count; i++)
        if (!placed[i] && (best < 0 || dir_offset[i] > dir_offset[best])) best = i;
      if (best < 0) break;
      placed[best] = 1'b1;
      if (dir_size[best] > pack_cursor) begin
        pack_cursor = '0;
        ovf         = 1'b1;
      end else begin
        pack_cursor = pack_cursor - dir_size[best];
      end
      awaited_requests.push_back('{KIND_MOVE, SlotW'(best), dir_offset[best], pack_cursor,
                                   dir_size[best], ovf, 1'b0});
    end
    awaited_requests.push_back('{KIND_DONE, '0, '0, pack_cursor, '0, ovf, 1'b1});
    if (ovf) overflow_pages++;
    pages_done++;
    dir_count = 0;
  endfunction

  task automatic send_entry(logic [OffW-1:0] off, logic [SizeW-1:0] sz,
                            logic del, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({sz, off});
    s_axis_tuser  <= del;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    plan_entry(off, sz, del, last);
  endtask

  // Mostly in-page records, some offset ties, some large records, some raw bits.
  function automatic void draw_entry(input logic [OffW-1:0] tie_off,
                                     output logic [OffW-1:0] off,
                                     output logic [SizeW-1:0] sz, output logic del);
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      off = OffW'($urandom_range(PageBytes));
      sz  = SizeW'($urandom_range(600));
    end else if (pick < 70) begin
      off = tie_off;
      sz  = SizeW'($urandom_range(PageBytes));
    end else if (pick < 88) begin
      off = OffW'($urandom_range(PageBytes));
      sz  = SizeW'($urandom_range(PageBytes, PageBytes / 4));
    end else begin
      off = OffW'($urandom);
      sz  = SizeW'($urandom);
    end
    del = ($urandom_range(99) < 25);
  endfunction

  task automatic send_page(int n);
    logic [OffW-1:0]  off;
    logic [OffW-1:0]  prev;
    logic [SizeW-1:0] sz;
    logic             del;
    prev = '0;
    for (int i = 0; i < n; i++) begin
      draw_entry(prev, off, sz, del);
      send_entry(off, sz, del, i == n - 1);
      prev = off;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_requests.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_pages();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // single live empty record at offset zero
    send_entry(13'd0, 13'd0, 1'b0, 1'b1);
    // single deleted slot: only the clear and done
    send_entry(13'd4096, 13'd4096, 1'b1, 1'b1);
    // offset ties, a deleted slot and an out-of-page offset
    send_entry(13'd100, 13'd50, 1'b0, 1'b0);
    send_entry(13'd4096, 13'd0, 1'b0, 1'b0);
    send_entry(13'd100, 13'd20, 1'b0, 1'b0);
    send_entry(13'd2000, 13'd300, 1'b1, 1'b0);
    send_entry(13'd8191, 13'd10, 1'b0, 1'b0);
    send_entry(13'd50, 13'd700, 1'b0, 1'b1);
    // cursor underflows mid-page and stays saturated
    send_entry(13'd30, 13'd3000, 1'b0, 1'b0);
    send_entry(13'd20, 13'd2000, 1'b0, 1'b0);
    send_entry(13'd10, 13'd100, 1'b0, 1'b1);
    // live sizes fill the page exactly
    send_entry(13'd4095, 13'd1024, 1'b0, 1'b0);
    send_entry(13'd3071, 13'd3072, 1'b0, 1'b1);
    // all-ones fields
    send_entry(13'd8191, 13'd8191, 1'b1, 1'b0);
    send_entry(13'd0, 13'd8191, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_full_directory();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_page(MaxSlots);
    // entries past capacity are dropped, the last flag still starts the run
    send_page(MaxSlots + 4);
    wait_idle();
  endtask

  task automatic test_random_pages(int target, int unsigned idle, int unsigned stall);
    int start;
    int pick;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = entries_stored;
    while (entries_stored - start < target) begin
      pick = $urandom_range(99);
      if (pick < 70)      send_page($urandom_range(8, 1));
      else if (pick < 93) send_page($urandom_range(MaxSlots, 9));
      else                send_page($urandom_range(MaxSlots + 8, MaxSlots + 1));
    end
    wait_idle();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_request = HoldOffCycles;
    // second page backs up behind the stalled output
    send_page(5);
    send_page(5);
    wait_idle();
  endtask

  // receiver: random stalls, plus a counted hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_request != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_request) @(posedge clk_i);
        hold_off_request = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    request_t got;
    request_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind    = result_kind_e'(m_axis_tuser);
      got.slot    = m_axis_tdata[5:0];
      got.old_off = m_axis_tdata[18:6];
      got.new_off = m_axis_tdata[31:19];
      got.size    = m_axis_tdata[44:32];
      got.ovf     = m_axis_tdata[45];
      got.fin     = m_axis_tlast;
      requests_checked++;
      if (awaited_requests.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: unexpected request: %s", $realtime, fmt_request(got));
      end else begin
        want = awaited_requests.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                     fmt_request(want), fmt_request(got));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d requests outstanding", awaited_requests.size());
    $display("** slotted_page_compactor: FAILED **");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_pages();
    test_full_directory();
    test_random_pages(110, 0, 0);
    test_random_pages(110, 53, 0);
    test_random_pages(110, 0, 53);
    test_random_pages(110, 21, 21);
    test_output_hold_off();
    repeat (DrainCycles) @(posedge clk_i);
    $display("compacted %0d pages from %0d stored entries (%0d dropped past capacity)",
             pages_done, entries_stored, entries_ignored);
    $display("checked %0d requests, %0d pages overflowed, %0d failures",
             requests_checked, overflow_pages, fail_count);
    if (fail_count == 0) begin
      $display("** slotted_page_compactor: PASSED **");
    end else begin
      $display("** slotted_page_compactor: FAILED **");
    end
    $finish;
  end

endmodule
